// ----- src/bmhq_pkg.sv -----
// Shared types and codes for the binary min-heap priority queue.
`timescale 1ns / 1ps

package bmhq_pkg;

  // Operation carried in the input tuser bit.
  typedef enum logic [0:0] {
    FN_PUSH = 1'b0,
    FN_POP  = 1'b1
  } func_t;

  // Completion status carried in the result tuser bits.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_UP    = 6'b000010,
    S_POP0  = 6'b000100,
    S_DOWN  = 6'b001000,
    S_PLACE = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  localparam int IN_KEY_BITS  = 16;
  localparam int IN_TAG_BITS  = 16;
  localparam int OUT_CNT_BITS = 8;

endpackage

// ----- src/bmhq_ram.sv -----
// Heap entry storage: one write port and two registered read ports.
`timescale 1ns / 1ps

module bmhq_ram #(
  parameter int DEPTH  = 128,
  parameter int ADDR_W = 7,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [DATA_W-1:0] rdata_a,
  output logic [DATA_W-1:0] rdata_b
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- src/binary_min_heap_queue_core.sv -----
// Binary min-heap priority queue: sequencer, key compares and result register.
// From accept to result: a push climbs through S_UP, one parent read and compare per level,
// and a pop reads the root and the last entry in S_POP0, then sinks through S_DOWN with
// both children read per level. A refused push, an empty pop, a push into an empty heap and
// a pop that leaves at most one entry skip those loops. One request at a time.
// Reset clears the entry count and control state; heap storage is not cleared.
`timescale 1ns / 1ps

module binary_min_heap_queue_core #(
  parameter int CAPACITY = 128,
  parameter int KEY_BITS = 16,
  parameter int TAG_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [31:0]        in_tdata,   // key_in [15:0], tag_in [31:16]
  input  bmhq_pkg::func_t    in_tuser,   // func [0]
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [39:0]        out_tdata,  // key_out [15:0], tag_out [31:16], fill_count [39:32]
  output bmhq_pkg::status_t  out_tuser   // status [1:0]
);

  import bmhq_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CW    = IDX_W + 2;
  localparam int ENT_W = KEY_BITS + TAG_BITS;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [KEY_BITS-1:0]  mkey_r, mkey_nxt;
  logic [TAG_BITS-1:0]  mtag_r, mtag_nxt;
  status_t              res_st_r, res_st_nxt;
  logic [KEY_BITS-1:0]  res_key_r, res_key_nxt;
  logic [TAG_BITS-1:0]  res_tag_r, res_tag_nxt;

  logic                 out_valid_r, out_valid_nxt;
  status_t              out_st_r, out_st_nxt;
  logic [15:0]          out_key_r, out_key_nxt;
  logic [15:0]          out_tag_r, out_tag_nxt;
  logic [7:0]           out_cnt_r, out_cnt_nxt;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [ENT_W-1:0]     ram_wdata;
  logic [IDX_W-1:0]     ram_raddr_a, ram_raddr_b;
  logic [ENT_W-1:0]     ram_rdata_a, ram_rdata_b;

  logic [63:0]          in_key64, in_tag64, res_key64, res_tag64;
  logic [31:0]          cnt32;
  logic [KEY_BITS-1:0]  in_key, rd_a_key, rd_b_key, ch_key;
  logic [TAG_BITS-1:0]  in_tag, rd_a_tag, rd_b_tag;
  logic [ENT_W-1:0]     ch_ent;
  logic [CNT_W-1:0]     cnt_m1;
  logic [CW-1:0]        cnt_w, cl_w, cr_w, ncl_w, ncr_w;
  logic [IDX_W-1:0]     idx_m1, par, par_m1, gpar, ch_idx;
  logic                 take_r;

  bmhq_ram #(
    .DEPTH  (CAPACITY),
    .ADDR_W (IDX_W),
    .DATA_W (ENT_W)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  // Field conversions between the fixed port widths and the stored widths.
  assign in_key64  = 64'(in_tdata[IN_KEY_BITS-1:0]);
  assign in_tag64  = 64'(in_tdata[IN_KEY_BITS+IN_TAG_BITS-1:IN_KEY_BITS]);
  assign in_key    = in_key64[KEY_BITS-1:0];
  assign in_tag    = in_tag64[TAG_BITS-1:0];
  assign res_key64 = 64'(res_key_r);
  assign res_tag64 = 64'(res_tag_r);
  assign cnt32     = 32'(cnt_r);

  assign rd_a_key = ram_rdata_a[KEY_BITS-1:0];
  assign rd_a_tag = ram_rdata_a[ENT_W-1:KEY_BITS];
  assign rd_b_key = ram_rdata_b[KEY_BITS-1:0];
  assign rd_b_tag = ram_rdata_b[ENT_W-1:KEY_BITS];

  // Heap index arithmetic.
  assign cnt_m1 = cnt_r - CNT_W'(1);
  assign cnt_w  = CW'(cnt_r);
  assign idx_m1 = idx_r - IDX_W'(1);
  assign par    = idx_m1 >> 1;
  assign par_m1 = par - IDX_W'(1);
  assign gpar   = par_m1 >> 1;
  assign cl_w   = CW'({idx_r, 1'b1});
  assign cr_w   = cl_w + CW'(1);

  // The right child is taken only when it exists and is strictly smaller.
  assign take_r = (cr_w < cnt_w) && (rd_b_key < rd_a_key);
  assign ch_ent = take_r ? ram_rdata_b : ram_rdata_a;
  assign ch_key = ch_ent[KEY_BITS-1:0];
  assign ch_idx = take_r ? cr_w[IDX_W-1:0] : cl_w[IDX_W-1:0];
  assign ncl_w  = CW'({ch_idx, 1'b1});
  assign ncr_w  = ncl_w + CW'(1);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_st_r;
  assign out_tdata  = {out_cnt_r, out_tag_r, out_key_r};

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    mkey_nxt      = mkey_r;
    mtag_nxt      = mtag_r;
    res_st_nxt    = res_st_r;
    res_key_nxt   = res_key_r;
    res_tag_nxt   = res_tag_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_st_nxt    = out_st_r;
    out_key_nxt   = out_key_r;
    out_tag_nxt   = out_tag_r;
    out_cnt_nxt   = out_cnt_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = {mtag_r, mkey_r};
    ram_raddr_a   = gpar;
    ram_raddr_b   = ncr_w[IDX_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          res_st_nxt  = ST_DONE;
          res_key_nxt = '0;
          res_tag_nxt = '0;
          if (in_tuser == FN_PUSH) begin
            if (cnt_w >= CW'(CAPACITY)) begin
              res_st_nxt = ST_FULL;
              state_nxt  = S_DONE;
            end else begin
              mkey_nxt = in_key;
              mtag_nxt = in_tag;
              cnt_nxt  = cnt_r + CNT_W'(1);
              idx_nxt  = cnt_r[IDX_W-1:0];
              if (cnt_r == '0) begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = {in_tag, in_key};
                state_nxt = S_DONE;
              end else begin
                ram_raddr_a = (cnt_r[IDX_W-1:0] - IDX_W'(1)) >> 1;
                state_nxt   = S_UP;
              end
            end
          end else begin
            if (cnt_r == '0) begin
              res_st_nxt = ST_EMPTY;
              state_nxt  = S_DONE;
            end else begin
              // Fetch the root and the last entry together.
              ram_raddr_a = '0;
              ram_raddr_b = cnt_m1[IDX_W-1:0];
              cnt_nxt     = cnt_m1;
              state_nxt   = S_POP0;
            end
          end
        end
      end

      S_UP: begin
        // The parent's entry is on read port A; the grandparent is fetched ahead.
        if (mkey_r < rd_a_key) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata_a;
          idx_nxt   = par;
          if (par == '0) begin
            state_nxt = S_PLACE;
          end else begin
            ram_raddr_a = gpar;
          end
        end else begin
          ram_we    = 1'b1;
          state_nxt = S_DONE;
        end
      end

      S_POP0: begin
        res_key_nxt = rd_a_key;
        res_tag_nxt = rd_a_tag;
        mkey_nxt    = rd_b_key;
        mtag_nxt    = rd_b_tag;
        idx_nxt     = '0;
        if (cnt_w > CW'(1)) begin
          ram_raddr_a = IDX_W'(1);
          ram_raddr_b = IDX_W'(2);
          state_nxt   = S_DOWN;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = ram_rdata_b;
          state_nxt = S_DONE;
        end
      end

      S_DOWN: begin
        // Both children are on the read ports; stop when the moved key is not greater.
        if (!(ch_key < mkey_r)) begin
          ram_we    = 1'b1;
          state_nxt = S_DONE;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = ch_ent;
          idx_nxt   = ch_idx;
          if (ncl_w < cnt_w) begin
            ram_raddr_a = ncl_w[IDX_W-1:0];
            ram_raddr_b = ncr_w[IDX_W-1:0];
          end else begin
            state_nxt = S_PLACE;
          end
        end
      end

      S_PLACE: begin
        ram_we    = 1'b1;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_key_nxt   = res_key64[IN_KEY_BITS-1:0];
          out_tag_nxt   = res_tag64[IN_TAG_BITS-1:0];
          out_cnt_nxt   = cnt32[OUT_CNT_BITS-1:0];
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    mkey_r    <= mkey_nxt;
    mtag_r    <= mtag_nxt;
    res_st_r  <= res_st_nxt;
    res_key_r <= res_key_nxt;
    res_tag_r <= res_tag_nxt;
    out_st_r  <= out_st_nxt;
    out_key_r <= out_key_nxt;
    out_tag_r <= out_tag_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

endmodule

// ----- tb/binary_min_heap_queue_core_tb.sv -----
// Self-checking testbench for the min-heap priority queue core, with its own heap predictor.
`timescale 1ns / 1ps

module binary_min_heap_queue_core_tb;
  import bmhq_pkg::*;

  localparam int CAPACITY = 128;
  localparam int ITEMS = 1450;
  localparam int STALL_LIMIT = 4000;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    func_t            fn;
    logic [15:0]      key;
    logic [15:0]      tag;
    logic             hold;   // wait for every outstanding result before presenting
    int unsigned      phase;  // idling profile in force for this request
  } heap_req_t;

  typedef struct {
    status_t     status;
    logic [15:0] key;
    logic [15:0] tag;
    logic [7:0]  fill;
  } heap_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  func_t       in_tuser = FN_PUSH;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  status_t     out_tuser;

  binary_min_heap_queue_core #(
    .CAPACITY(CAPACITY),
    .KEY_BITS(16),
    .TAG_BITS(16)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  heap_req_t    request_queue[$];
  heap_result_t predicted_results[$];

  // Shadow copy of the heap contents.
  logic [15:0]  heap_keys_q[CAPACITY];
  logic [15:0]  heap_tags_q[CAPACITY];
  int unsigned  heap_count_q = 0;

  int unsigned  fail_count = 0;
  int unsigned  stall_cycles = 0;
  int unsigned  cur_phase = 0;
  int unsigned  gen_count = 0;
  int unsigned  gen_total = 0;
  logic         req_taken = 1'b0;

  function automatic heap_result_t predict_heap_op(func_t fn, logic [15:0] key,
                                                   logic [15:0] tag);
    heap_result_t r;
    int unsigned  i;
    int unsigned  up;
    int unsigned  c;
    logic [15:0]  mkey;
    logic [15:0]  mtag;
    r.status = ST_DONE;
    r.key = '0;
    r.tag = '0;
    i = 0;
    if (fn == FN_PUSH) begin
      if (heap_count_q >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        i = heap_count_q;
        heap_count_q++;
        // An equal parent key stops the climb.
        while (i > 0) begin
          up = (i - 1) / 2;
          if (!(key < heap_keys_q[up])) break;
          heap_keys_q[i] = heap_keys_q[up];
          heap_tags_q[i] = heap_tags_q[up];
          i = up;
        end
        heap_keys_q[i] = key;
        heap_tags_q[i] = tag;
      end
    end else begin
      if (heap_count_q == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.key = heap_keys_q[0];
        r.tag = heap_tags_q[0];
        heap_count_q--;
        mkey = heap_keys_q[heap_count_q];
        mtag = heap_tags_q[heap_count_q];
        while (2 * i + 1 < heap_count_q) begin
          c = 2 * i + 1;
          if (c + 1 < heap_count_q && heap_keys_q[c + 1] < heap_keys_q[c]) c++;
          if (mkey <= heap_keys_q[c]) break;
          heap_keys_q[i] = heap_keys_q[c];
          heap_tags_q[i] = heap_tags_q[c];
          i = c;
        end
        heap_keys_q[i] = mkey;
        heap_tags_q[i] = mtag;
      end
    end
    r.fill = 8'(heap_count_q);
    return r;
  endfunction

  task automatic note_failure(input string msg);
    if (fail_count < MAX_REPORTS) $display("%0t mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  // Sender idle share per phase; the receiver uses the opposite profile.
  function automatic int unsigned send_idle_pct(int unsigned phase);
    case (phase)
      0: return 33;
      1: return 57;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned recv_idle_pct(int unsigned phase);
    case (phase)
      0: return 57;
      1: return 33;
      default: return 0;
    endcase
  endfunction

  always @(negedge clk) begin : drive_requests
    heap_req_t nxt;
    if (rst_n) begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct(cur_phase));
      if (!in_tvalid || req_taken) begin
        if (request_queue.size() > 0 &&
            (!request_queue[0].hold || predicted_results.size() == 0) &&
            $urandom_range(99) >= send_idle_pct(request_queue[0].phase)) begin
          nxt = request_queue.pop_front();
          cur_phase = nxt.phase;
          in_tdata <= {nxt.tag, nxt.key};
          in_tuser <= nxt.fn;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_channels
    heap_result_t exp_r;
    heap_result_t got_r;
    if (rst_n) begin
      req_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        predicted_results.push_back(predict_heap_op(in_tuser, in_tdata[15:0],
                                                    in_tdata[31:16]));
      end
      if (out_tvalid && out_tready) begin
        got_r.status = out_tuser;
        got_r.key = out_tdata[15:0];
        got_r.tag = out_tdata[31:16];
        got_r.fill = out_tdata[39:32];
        if (predicted_results.size() == 0) begin
          note_failure($sformatf("result with nothing pending: status %0d key %h tag %h fill %0d",
                                 got_r.status, got_r.key, got_r.tag, got_r.fill));
        end else begin
          exp_r = predicted_results.pop_front();
          if (got_r.status != exp_r.status)
            note_failure($sformatf("status expected %0d got %0d", exp_r.status, got_r.status));
          if (got_r.key != exp_r.key)
            note_failure($sformatf("key expected %h got %h", exp_r.key, got_r.key));
          if (got_r.tag != exp_r.tag)
            note_failure($sformatf("tag expected %h got %h", exp_r.tag, got_r.tag));
          if (got_r.fill != exp_r.fill)
            note_failure($sformatf("fill expected %0d got %0d", exp_r.fill, got_r.fill));
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("binary_min_heap_queue_core_tb: FAIL");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic add_req(input func_t fn, input logic [15:0] key, input logic [15:0] tag,
                         input logic hold);
    heap_req_t r;
    r.fn = fn;
    r.key = key;
    r.tag = tag;
    r.hold = hold;
    r.phase = (gen_total * 3) / ITEMS;
    if (r.phase > 2) r.phase = 2;
    request_queue.push_back(r);
    gen_total++;
    if (fn == FN_PUSH && gen_count < CAPACITY) gen_count++;
    if (fn == FN_POP && gen_count > 0) gen_count--;
  endtask

  // Keys lean toward a narrow range so that equal keys meet often.
  function automatic logic [15:0] pick_key();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom_range(7));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    int unsigned run_len;
    int unsigned push_pct;
    int unsigned fills;
    int unsigned extra;
    fills = 0;

    // Empty pops, extreme keys and tags, equal keys on both sift paths.
    add_req(FN_POP, 16'hFFFF, 16'hFFFF, 1'b0);
    add_req(FN_POP, 16'h0000, 16'h0000, 1'b0);
    add_req(FN_PUSH, 16'h8000, 16'h0001, 1'b0);
    add_req(FN_PUSH, 16'h8000, 16'h0002, 1'b0);
    add_req(FN_PUSH, 16'hFFFF, 16'hFFFF, 1'b0);
    add_req(FN_PUSH, 16'h0000, 16'h0000, 1'b0);
    add_req(FN_PUSH, 16'h8000, 16'h0003, 1'b0);
    add_req(FN_PUSH, 16'h0000, 16'hAAAA, 1'b0);
    add_req(FN_PUSH, 16'h4000, 16'h5555, 1'b0);
    repeat (8) add_req(FN_POP, 16'h0000, 16'h0000, 1'b0);
    add_req(FN_PUSH, 16'hFFFF, 16'h0000, 1'b0);
    add_req(FN_PUSH, 16'h0001, 16'hFFFF, 1'b0);
    repeat (3) add_req(FN_POP, 16'hFFFF, 16'hFFFF, 1'b0);

    while (gen_total < ITEMS) begin
      if ($urandom_range(9) == 0 && fills < 2 && gen_total + 300 < ITEMS) begin
        // Fill to capacity, knock on the full heap, then drain past empty.
        fills++;
        extra = $urandom_range(3, 1);
        add_req(FN_PUSH, pick_key(), 16'($urandom), 1'b1);
        while (gen_count < CAPACITY) add_req(FN_PUSH, pick_key(), 16'($urandom), 1'b0);
        repeat (extra) add_req(FN_PUSH, pick_key(), 16'($urandom), 1'b0);
        while (gen_count > 0) add_req(FN_POP, 16'($urandom), 16'($urandom), 1'b0);
        repeat (extra) add_req(FN_POP, 16'($urandom), 16'($urandom), 1'b0);
      end else begin
        run_len = $urandom_range(50, 10);
        push_pct = $urandom_range(80, 30);
        repeat (run_len) begin
          add_req(($urandom_range(99) < push_pct) ? FN_PUSH : FN_POP, pick_key(),
                  16'($urandom), ($urandom_range(39) == 0));
        end
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (request_queue.size() != 0 || in_tvalid) @(posedge clk);
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    if (fail_count == 0 && predicted_results.size() == 0) begin
      $display("binary_min_heap_queue_core_tb: PASS");
    end else begin
      $display("binary_min_heap_queue_core_tb: FAIL");
    end
    $finish;
  end

endmodule
